>>> hw/rtl/fifo_queue_with_search_update_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the FIFO queue with content search
// Concurrent checks in simulation; empty bodies for synthesis.
// ----------------------------------------------------------------------------
`ifndef FIFO_QUEUE_WITH_SEARCH_UPDATE_TOP_DEFINES_SVH
`define FIFO_QUEUE_WITH_SEARCH_UPDATE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Check a property while reset is released
`define FQSU_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("fqsu assertion failed");
// Check a property at every edge, reset included
`define FQSU_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("fqsu assertion failed");
`else
`define FQSU_ASSERT(lbl, clk, rstn, prop)
`define FQSU_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/fqsu_pkg.sv
// ----------------------------------------------------------------------------
// fqsu_pkg
// Shared types and constants of the FIFO queue with content search.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fqsu_pkg;

  localparam int unsigned DataW     = 32;
  localparam int unsigned CmdW      = 2;
  localparam int unsigned StatusW   = 2;
  localparam int unsigned CountOutW = 5;

  typedef enum logic [CmdW-1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_DEQUEUE = 2'd1,
    CMD_UPDATE  = 2'd2,
    CMD_SEARCH  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_FULL      = 2'd2,
    STS_NOT_FOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FINISH
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/fqsu_cmd_if.sv
// ----------------------------------------------------------------------------
// fqsu_cmd_if
// Command channel: valid/ready handshake with command, key and new value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fqsu_cmd_if
  import fqsu_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic [CmdW-1:0]         command;
  logic signed [DataW-1:0] value;
  logic signed [DataW-1:0] new_value;

  modport source (output valid, output command, output value, output new_value,
                  input ready);
  modport sink   (input valid, input command, input value, input new_value,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fqsu_rsp_if.sv
// ----------------------------------------------------------------------------
// fqsu_rsp_if
// Response channel: valid/ready handshake with status, found flag and count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface fqsu_rsp_if
  import fqsu_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [StatusW-1:0]   status;
  logic                 found;
  logic [CountOutW-1:0] entry_count;

  modport source (output valid, output status, output found, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input found, input entry_count,
                  output ready);
endinterface

`default_nettype wire

>>> hw/rtl/fifo_queue_with_search_update_top.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search_update_top
// Enqueue and dequeue: result registered in the cycle after the command is taken.
// Search and update: one entry is read per cycle through the single read port
// of the entry store, and the compare runs in the cycle after the read.
// Search and update on an empty queue answer in the cycle after the transaction.
// Throughput: one command in flight; the next is taken once its result is out
// or being taken. Reset (async, active low) empties the queue; store unset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "fifo_queue_with_search_update_top_defines.svh"

module fifo_queue_with_search_update_top
  import fqsu_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  fqsu_cmd_if.sink   cmd_i,
  fqsu_rsp_if.source rsp_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // Ring advance with wrap at the last entry
  function automatic logic [IdxW-1:0] ring_next(input logic [IdxW-1:0] idx);
    ring_next = (idx == IdxW'(DEPTH - 1)) ? '0 : idx + 1'b1;
  endfunction

  state_e                  state_q, state_d;
  logic [IdxW-1:0]         head_q, head_d;
  logic [IdxW-1:0]         tail_q, tail_d;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [IdxW-1:0]         walk_addr_q, walk_addr_d;
  logic [CntW-1:0]         issued_q, issued_d;
  logic                    cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0]         cmp_addr_q, cmp_addr_d;
  logic signed [DataW-1:0] key_q, key_d;
  logic signed [DataW-1:0] nval_q, nval_d;
  logic                    is_upd_q, is_upd_d;
  status_e                 pend_sts_q, pend_sts_d;
  logic                    pend_fnd_q, pend_fnd_d;

  logic                    out_valid_q, out_valid_d;
  status_e                 out_sts_q, out_sts_d;
  logic                    out_fnd_q, out_fnd_d;
  logic [CountOutW-1:0]    out_cnt_q, out_cnt_d;

  logic                    out_free;
  logic                    accept;
  logic                    hit;
  cmd_e                    cmd;

  logic                    mem_we;
  logic [IdxW-1:0]         mem_waddr;
  logic signed [DataW-1:0] mem_wdata;
  logic signed [DataW-1:0] mem_rdata;

  fqsu_mem #(
    .DEPTH (DEPTH),
    .AW    (IdxW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (walk_addr_q),
    .rdata_o (mem_rdata)
  );

  assign out_free    = !out_valid_q || rsp_o.ready;
  assign cmd_i.ready = (state_q == ST_IDLE) && out_free;
  assign accept      = cmd_i.valid && cmd_i.ready;
  assign cmd         = cmd_e'(cmd_i.command);
  assign hit         = cmp_vld_q && (mem_rdata == key_q);

  // Sequencer: command decode, ring walk, result load
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    tail_d      = tail_q;
    cnt_d       = cnt_q;
    walk_addr_d = walk_addr_q;
    issued_d    = issued_q;
    cmp_vld_d   = 1'b0;
    cmp_addr_d  = cmp_addr_q;
    key_d       = key_q;
    nval_d      = nval_q;
    is_upd_d    = is_upd_q;
    pend_sts_d  = pend_sts_q;
    pend_fnd_d  = pend_fnd_q;
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_sts_d   = out_sts_q;
    out_fnd_d   = out_fnd_q;
    out_cnt_d   = out_cnt_q;
    mem_we      = 1'b0;
    mem_waddr   = tail_q;
    mem_wdata   = cmd_i.value;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          out_fnd_d = 1'b0;
          out_sts_d = STS_OK;
          unique case (cmd)
            CMD_ENQUEUE: begin
              if (cnt_q == CntW'(DEPTH)) begin
                out_sts_d = STS_FULL;
              end else begin
                mem_we = 1'b1;
                tail_d = ring_next(tail_q);
                cnt_d  = cnt_q + 1'b1;
              end
              out_valid_d = 1'b1;
            end
            CMD_DEQUEUE: begin
              if (cnt_q == '0) begin
                out_sts_d = STS_EMPTY;
              end else begin
                head_d = ring_next(head_q);
                cnt_d  = cnt_q - 1'b1;
              end
              out_valid_d = 1'b1;
            end
            CMD_UPDATE, CMD_SEARCH: begin
              if (cnt_q == '0) begin
                out_sts_d   = STS_NOT_FOUND;
                out_valid_d = 1'b1;
              end else begin
                key_d       = cmd_i.value;
                nval_d      = cmd_i.new_value;
                is_upd_d    = (cmd == CMD_UPDATE);
                walk_addr_d = head_q;
                issued_d    = '0;
                state_d     = ST_WALK;
              end
            end
            default: ;
          endcase
          out_cnt_d = CountOutW'(cnt_d);
        end
      end

      ST_WALK: begin
        // Issue the next read while entries remain
        if (issued_q != cnt_q) begin
          cmp_vld_d   = 1'b1;
          cmp_addr_d  = walk_addr_q;
          walk_addr_d = ring_next(walk_addr_q);
          issued_d    = issued_q + 1'b1;
        end
        // Compare the entry read last cycle
        if (hit) begin
          mem_we     = is_upd_q;
          mem_waddr  = cmp_addr_q;
          mem_wdata  = nval_q;
          pend_sts_d = STS_OK;
          pend_fnd_d = 1'b1;
          cmp_vld_d  = 1'b0;
          state_d    = ST_FINISH;
        end else if (issued_q == cnt_q) begin
          pend_sts_d = STS_NOT_FOUND;
          pend_fnd_d = 1'b0;
          cmp_vld_d  = 1'b0;
          state_d    = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sts_d   = pend_sts_q;
          out_fnd_d   = pend_fnd_q;
          out_cnt_d   = CountOutW'(cnt_q);
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      issued_q    <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      cnt_q       <= cnt_d;
      issued_q    <= issued_d;
      cmp_vld_q   <= cmp_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and walk registers
  always_ff @(posedge clk_i) begin
    walk_addr_q <= walk_addr_d;
    cmp_addr_q  <= cmp_addr_d;
    key_q       <= key_d;
    nval_q      <= nval_d;
    is_upd_q    <= is_upd_d;
    pend_sts_q  <= pend_sts_d;
    pend_fnd_q  <= pend_fnd_d;
    out_sts_q   <= out_sts_d;
    out_fnd_q   <= out_fnd_d;
    out_cnt_q   <= out_cnt_d;
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_sts_q;
  assign rsp_o.found       = out_fnd_q;
  assign rsp_o.entry_count = out_cnt_q;

  // Checks
  `FQSU_ASSERT_ALWAYS(a_cnt_bound, clk_i, !rst_ni || (cnt_q <= CntW'(DEPTH)))
  `FQSU_ASSERT(a_walk_bound, clk_i, rst_ni, (state_q == ST_WALK) |-> (issued_q <= cnt_q))
  `FQSU_ASSERT(a_cnt_hold_busy, clk_i, rst_ni, (state_q != ST_IDLE) |=> $stable(cnt_q))
  `FQSU_ASSERT(a_found_ok, clk_i, rst_ni, (out_valid_q && out_fnd_q) |-> (out_sts_q == STS_OK))

endmodule

`default_nettype wire

>>> hw/rtl/fqsu_mem.sv
// ----------------------------------------------------------------------------
// fqsu_mem
// Entry store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fqsu_mem
  import fqsu_pkg::*;
#(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = 4
) (
  input  wire logic                    clk_i,
  input  wire logic                    we_i,
  input  wire logic [AW-1:0]           waddr_i,
  input  wire logic signed [DataW-1:0] wdata_i,
  input  wire logic [AW-1:0]           raddr_i,
  output logic signed [DataW-1:0]      rdata_o
);

  logic signed [DataW-1:0] mem_q [DEPTH];

  // Write one entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read one entry per cycle
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

>>> tb/fifo_queue_with_search_update_top_tb.sv
// ----------------------------------------------------------------------------
// FIFO queue with content search: self-checking testbench
// Drives enqueue, dequeue, update-first-match and search commands through the
// command channel, mirrors the ring in a scoreboard and checks every response
// field. Both channels stall at random, except during one long steady stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fifo_queue_with_search_update_top_tb;
  import fqsu_pkg::*;

  localparam int unsigned DEPTH          = 16;
  localparam int unsigned RANDOM_ITEMS   = 1750;
  localparam int unsigned IDLE_PCT       = 19;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 2 * DEPTH + 8;

  typedef struct packed {
    status_e              status;
    logic                 found;
    logic [CountOutW-1:0] entry_count;
  } queue_result_t;

  // Ring mirror of the queue and the responses it predicts
  class queue_scoreboard;
    logic signed [DataW-1:0] ring [DEPTH];
    int unsigned             head_pos;
    int unsigned             tail_pos;
    int unsigned             held;
    queue_result_t           expected_results [$];
    int unsigned             errors;
    int unsigned             cmd_seen [4];
    int unsigned             hits;
    int unsigned             full_refusals;
    int unsigned             empty_refusals;
    int unsigned             responses;

    function new();
      head_pos = 0;
      tail_pos = 0;
      held     = 0;
      errors   = 0;
      hits     = 0;
      full_refusals  = 0;
      empty_refusals = 0;
      responses      = 0;
      foreach (cmd_seen[i]) cmd_seen[i] = 0;
    endfunction

    // Return the ring slot of the first held entry equal to key, or -1
    function int match_slot(logic signed [DataW-1:0] key);
      int unsigned slot;
      slot = head_pos;
      for (int unsigned n = 0; n < held; n++) begin
        if (ring[slot] == key) return int'(slot);
        slot = (slot + 1) % DEPTH;
      end
      return -1;
    endfunction

    // Pick a value currently held, for keys that hit
    function logic signed [DataW-1:0] held_value();
      if (held == 0) return $urandom;
      return ring[(head_pos + $urandom_range(held - 1)) % DEPTH];
    endfunction

    // Apply one accepted command and queue the response it should produce
    function void note_command(cmd_e cmd, logic signed [DataW-1:0] key,
                               logic signed [DataW-1:0] repl);
      queue_result_t r;
      int            slot;
      r.status = STS_OK;
      r.found  = 1'b0;
      cmd_seen[cmd]++;
      case (cmd)
        CMD_ENQUEUE: begin
          if (held >= DEPTH) begin
            r.status = STS_FULL;
            full_refusals++;
          end else begin
            ring[tail_pos] = key;
            tail_pos = (tail_pos + 1) % DEPTH;
            held++;
          end
        end
        CMD_DEQUEUE: begin
          if (held == 0) begin
            r.status = STS_EMPTY;
            empty_refusals++;
          end else begin
            head_pos = (head_pos + 1) % DEPTH;
            held--;
          end
        end
        default: begin
          slot = match_slot(key);
          if (slot >= 0) begin
            if (cmd == CMD_UPDATE) ring[slot] = repl;
            r.found = 1'b1;
            hits++;
          end else begin
            r.status = STS_NOT_FOUND;
          end
        end
      endcase
      r.entry_count = held[CountOutW-1:0];
      expected_results.push_back(r);
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one response transaction with the oldest prediction
    task check_response(logic [StatusW-1:0] status, logic found,
                        logic [CountOutW-1:0] entry_count);
      queue_result_t want;
      responses++;
      if (expected_results.size() == 0) begin
        report_mismatch("response with no command outstanding");
      end else begin
        want = expected_results.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        if (found !== want.found)
          report_mismatch($sformatf("found %0b, expected %0b", found, want.found));
        if (entry_count !== want.entry_count)
          report_mismatch($sformatf("entry_count %0d, expected %0d",
                                    entry_count, want.entry_count));
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  fqsu_cmd_if cmd_if ();
  fqsu_rsp_if rsp_if ();

  fifo_queue_with_search_update_top #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  queue_scoreboard sb = new();

  int unsigned cmd_idle_pct = IDLE_PCT;
  int unsigned rsp_idle_pct = IDLE_PCT;
  int unsigned stall_cycles = 0;

  // Key pool with extremes, so duplicates and first-match cases come up often
  logic signed [DataW-1:0] key_pool [8] = '{
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0000_0000, 32'shFFFF_FFFF,
    32'sh0000_0001, 32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0000_1234
  };

  // Toggle the clock
  initial clk_i = 1'b0;
  always #4 clk_i = ~clk_i;

  // Hold inputs known from time zero
  initial begin
    rst_ni           = 1'b0;
    cmd_if.valid     = 1'b0;
    cmd_if.command   = CMD_ENQUEUE;
    cmd_if.value     = '0;
    cmd_if.new_value = '0;
    rsp_if.ready     = 1'b0;
  end

  // Drop response ready at random
  always @(negedge clk_i) begin
    rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
  end

  // Check each response transaction
  always @(posedge clk_i) begin
    if (rst_ni && rsp_if.valid && rsp_if.ready)
      sb.check_response(rsp_if.status, rsp_if.found, rsp_if.entry_count);
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("fifo_queue_with_search_update_top_tb: done, errors");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Present one command, idling first at random, and wait for the transaction
  task automatic issue_command(input cmd_e cmd, input logic signed [DataW-1:0] key,
                               input logic signed [DataW-1:0] repl);
    while ($urandom_range(99) < cmd_idle_pct) begin
      @(negedge clk_i);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk_i);
    cmd_if.valid     <= 1'b1;
    cmd_if.command   <= cmd;
    cmd_if.value     <= key;
    cmd_if.new_value <= repl;
    do @(posedge clk_i); while (!cmd_if.ready);
    sb.note_command(cmd, key, repl);
  endtask

  // Choose a command; the phase steers the fill level up, down or to full
  function automatic cmd_e pick_command(int unsigned phase);
    int unsigned roll;
    roll = $urandom_range(99);
    case (phase)
      0: return (roll < 50) ? CMD_ENQUEUE : (roll < 65) ? CMD_DEQUEUE :
                (roll < 82) ? CMD_UPDATE : CMD_SEARCH;
      1: return (roll < 15) ? CMD_ENQUEUE : (roll < 55) ? CMD_DEQUEUE :
                (roll < 77) ? CMD_UPDATE : CMD_SEARCH;
      2: return (roll < 30) ? CMD_ENQUEUE : (roll < 50) ? CMD_DEQUEUE :
                (roll < 75) ? CMD_UPDATE : CMD_SEARCH;
      default: return (roll < 65) ? CMD_ENQUEUE : (roll < 72) ? CMD_DEQUEUE :
                      (roll < 86) ? CMD_UPDATE : CMD_SEARCH;
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    return ($urandom_range(1)) ? key_pool[$urandom_range(7)] : $urandom;
  endfunction

  // Key for search and update: mostly hits, some near misses, some noise
  function automatic logic signed [DataW-1:0] pick_key();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return sb.held_value();
    if (roll < 80) return key_pool[$urandom_range(7)];
    return $urandom;
  endfunction

  initial begin
    cmd_e        cmd;
    logic signed [DataW-1:0] key;

    // Reset once
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: refusals on the empty queue
    issue_command(CMD_SEARCH,  32'sh0000_0000, 32'sh0000_0000);
    issue_command(CMD_UPDATE,  32'sh0000_0000, 32'sh7FFF_FFFF);
    issue_command(CMD_DEQUEUE, 32'sh0000_0000, 32'sh0000_0000);

    // Directed: extremes, hit and miss, first of duplicates replaced
    issue_command(CMD_ENQUEUE, 32'sh8000_0000, 32'sh0000_0000);
    issue_command(CMD_ENQUEUE, 32'sh7FFF_FFFF, 32'sh0000_0000);
    issue_command(CMD_ENQUEUE, 32'sh0000_0000, 32'sh0000_0000);
    issue_command(CMD_ENQUEUE, 32'shFFFF_FFFF, 32'sh0000_0000);
    issue_command(CMD_SEARCH,  32'sh7FFF_FFFF, 32'sh0000_0000);
    issue_command(CMD_SEARCH,  32'sh0000_0005, 32'sh0000_0000);
    issue_command(CMD_UPDATE,  32'sh8000_0000, 32'sh7FFF_FFFF);
    issue_command(CMD_UPDATE,  32'sh7FFF_FFFF, 32'sh8000_0000);
    issue_command(CMD_UPDATE,  32'sh0000_0005, 32'shFFFF_FFFF);
    issue_command(CMD_DEQUEUE, 32'sh0000_0000, 32'sh0000_0000);

    // Directed: fill to full across the wrap, refuse one more, hit the tail
    for (int unsigned i = 0; i < DEPTH - 3; i++)
      issue_command(CMD_ENQUEUE, 32'sh0000_0100 + i, 32'sh0000_0000);
    issue_command(CMD_ENQUEUE, 32'sh0BAD_0BAD, 32'sh0000_0000);
    issue_command(CMD_SEARCH,  32'sh0000_0100 + DEPTH - 4, 32'sh0000_0000);
    issue_command(CMD_DEQUEUE, 32'sh0000_0000, 32'sh0000_0000);

    // Random traffic in phases, with one long stretch without stalls
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= 700 && i < 1000) begin
        cmd_idle_pct = 0;
        rsp_idle_pct = 0;
      end else begin
        cmd_idle_pct = IDLE_PCT;
        rsp_idle_pct = IDLE_PCT;
      end
      cmd = pick_command((i / 120) % 4);
      key = (cmd == CMD_ENQUEUE || cmd == CMD_DEQUEUE) ? pick_value() : pick_key();
      issue_command(cmd, key, pick_value());
    end
    @(negedge clk_i);
    cmd_if.valid <= 1'b0;
    rsp_idle_pct = IDLE_PCT;

    // Drain outstanding responses, then watch for strays
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d responses: %0d enqueue, %0d dequeue, %0d update, %0d search",
             sb.responses, sb.cmd_seen[CMD_ENQUEUE], sb.cmd_seen[CMD_DEQUEUE],
             sb.cmd_seen[CMD_UPDATE], sb.cmd_seen[CMD_SEARCH]);
    $display("key hits %0d, full refusals %0d, empty refusals %0d, mismatches %0d",
             sb.hits, sb.full_refusals, sb.empty_refusals, sb.errors);
    if (sb.errors == 0) begin
      $display("fifo_queue_with_search_update_top_tb: done, clean");
    end else begin
      $display("fifo_queue_with_search_update_top_tb: done, errors");
    end
    $finish;
  end

endmodule
